// ===== rtl/spl_pkg.sv =====
package spl_pkg;

   localparam int SAMPLE_W    = 24;
   localparam int SCALED_W    = 28;
   localparam int COEF_W      = 16;
   localparam int MAG_W       = 27;
   localparam int DIV_STEPS   = 24;
   localparam int CNT_W       = 5;
   localparam int CSR_INDEX_W = 8;

   localparam logic [CSR_INDEX_W-1:0] REG_ATTACK_COEF  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RELEASE_COEF = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PREAMP_GAIN  = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LIMIT_LEVEL  = 8'd3;

   localparam logic [COEF_W-1:0] ATTACK_COEF_RESET  = 16'd64181;
   localparam logic [COEF_W-1:0] RELEASE_COEF_RESET = 16'd65468;
   localparam logic [COEF_W-1:0] PREAMP_GAIN_RESET  = 16'd4096;
   localparam logic [COEF_W-1:0] LIMIT_LEVEL_RESET  = 16'd3891;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_MULT,
      ST_UPDATE,
      ST_PREP,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic scale;
      logic env_mult;
      logic env_update;
      logic prep;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic bypass;
   } status_type;

   typedef struct packed {
      logic [COEF_W-1:0] attack_coef;
      logic [COEF_W-1:0] release_coef;
      logic [COEF_W-1:0] preamp_gain;
      logic [COEF_W-1:0] limit_level;
   } cfg_type;

endpackage

// ===== rtl/stereo_peak_limiter.sv =====
// Channel  Direction  Handshake                 Word
// req      in         req_valid / req_stall     req_sample_left, req_sample_right
// rsp      out        rsp_valid / rsp_stall     rsp_out_left, rsp_out_right, rsp_env_magnitude
// csr      in         csr_valid / csr_ready     csr_index, csr_wdata
//
// When limiting applies, rsp_valid rises after SCALE, MULT, UPDATE, PREP, the 24 steps of
// the two restoring dividers and DONE; when the dry input passes, PREP goes straight to DONE.
// One word is processed at a time; the next is accepted the cycle after the result enters
// the output register, even if that result is still stalled.
// Reset is synchronous and restores the register defaults and a zero envelope.
module stereo_peak_limiter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [spl_pkg::SAMPLE_W-1:0]  req_sample_left,
   input  logic signed [spl_pkg::SAMPLE_W-1:0]  req_sample_right,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [spl_pkg::SAMPLE_W-1:0]  rsp_out_left,
   output logic signed [spl_pkg::SAMPLE_W-1:0]  rsp_out_right,
   output logic [spl_pkg::MAG_W-1:0]            rsp_env_magnitude,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [spl_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [spl_pkg::COEF_W-1:0]           csr_wdata
);

   spl_pkg::cfg_type    cfg;
   spl_pkg::cmd_type    cmd;
   spl_pkg::status_type status;

   spl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   spl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   spl_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .cfg           (cfg),
      .sample_left   (req_sample_left),
      .sample_right  (req_sample_right),
      .status        (status),
      .out_left      (rsp_out_left),
      .out_right     (rsp_out_right),
      .env_magnitude (rsp_env_magnitude)
   );

endmodule

// ===== rtl/spl_csr.sv =====
module spl_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [spl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [spl_pkg::COEF_W-1:0]         csr_wdata,
   output spl_pkg::cfg_type                   cfg
);

   spl_pkg::cfg_type cfg_ff;
   spl_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            spl_pkg::REG_ATTACK_COEF:  cfg_in.attack_coef  = csr_wdata;
            spl_pkg::REG_RELEASE_COEF: cfg_in.release_coef = csr_wdata;
            spl_pkg::REG_PREAMP_GAIN:  cfg_in.preamp_gain  = csr_wdata;
            spl_pkg::REG_LIMIT_LEVEL:  cfg_in.limit_level  = csr_wdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attack_coef  <= spl_pkg::ATTACK_COEF_RESET;
         cfg_ff.release_coef <= spl_pkg::RELEASE_COEF_RESET;
         cfg_ff.preamp_gain  <= spl_pkg::PREAMP_GAIN_RESET;
         cfg_ff.limit_level  <= spl_pkg::LIMIT_LEVEL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/spl_ctrl.sv =====
module spl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  spl_pkg::status_type   status,
   output spl_pkg::cmd_type      cmd
);

   spl_pkg::state_type            state_ff;
   spl_pkg::state_type            state_in;
   logic [spl_pkg::CNT_W-1:0]     cnt_ff;
   logic [spl_pkg::CNT_W-1:0]     cnt_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;

   assign req_stall = (state_ff != spl_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         spl_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = spl_pkg::ST_SCALE;
            end
         end
         spl_pkg::ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = spl_pkg::ST_MULT;
         end
         spl_pkg::ST_MULT: begin
            cmd.env_mult = 1'b1;
            state_in     = spl_pkg::ST_UPDATE;
         end
         spl_pkg::ST_UPDATE: begin
            cmd.env_update = 1'b1;
            state_in       = spl_pkg::ST_PREP;
         end
         spl_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            cnt_in   = spl_pkg::CNT_W'(spl_pkg::DIV_STEPS - 1);
            state_in = status.bypass ? spl_pkg::ST_DONE : spl_pkg::ST_DIVIDE;
         end
         spl_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = spl_pkg::ST_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         spl_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = spl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spl_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == spl_pkg::ST_SCALE)
      else $error("accepted word did not start processing");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == spl_pkg::ST_DIVIDE |-> cnt_ff < spl_pkg::CNT_W'(spl_pkg::DIV_STEPS))
      else $error("divide step count out of range");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == spl_pkg::ST_DONE)
      else $error("result raised outside the done state");

endmodule

// ===== rtl/spl_datapath.sv =====
module spl_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  spl_pkg::cmd_type                     cmd,
   input  spl_pkg::cfg_type                     cfg,
   input  logic signed [spl_pkg::SAMPLE_W-1:0]  sample_left,
   input  logic signed [spl_pkg::SAMPLE_W-1:0]  sample_right,
   output spl_pkg::status_type                  status,
   output logic signed [spl_pkg::SAMPLE_W-1:0]  out_left,
   output logic signed [spl_pkg::SAMPLE_W-1:0]  out_right,
   output logic [spl_pkg::MAG_W-1:0]            env_magnitude
);

   localparam logic [27:0] ONE_Q23 = 28'h0800000;

   function automatic logic [23:0] div_result(input logic ovf, input logic neg,
                                              input logic [23:0] q);
      logic [23:0] r;
      if (ovf) begin
         r = neg ? 24'h800000 : 24'h7FFFFF;
      end else if (neg) begin
         r = (q > 24'h800000) ? 24'h800000 : 24'(-q);
      end else begin
         r = (q > 24'h7FFFFF) ? 24'h7FFFFF : q;
      end
      return r;
   endfunction

   logic signed [1:0][23:0]   smp_ff;
   logic signed [1:0][27:0]   scl_ff;
   logic signed [1:0][27:0]   scl_in;
   logic signed [27:0]        peak_ff;
   logic signed [27:0]        peak_in;
   logic signed [45:0]        eprod_ff;
   logic signed [45:0]        eprod_in;
   logic signed [27:0]        env_ff;
   logic signed [27:0]        env_in;
   logic [27:0]               env_abs_ff;
   logic [27:0]               env_abs_in;
   logic                      bypass_ff;
   logic                      bypass_in;
   logic [28:0]               dmag_ff;
   logic [28:0]               dmag_in;
   logic [1:0]                ovf_ff;
   logic [1:0]                ovf_in;
   logic [1:0]                neg_ff;
   logic [1:0]                neg_in;
   logic [1:0]                nb_ff;
   logic [1:0]                nb_in;
   logic [1:0][28:0]          rem_ff;
   logic [1:0][28:0]          rem_in;
   logic [1:0][23:0]          q_ff;
   logic [1:0][23:0]          q_in;
   logic signed [1:0][23:0]   out_ff;
   logic signed [1:0][23:0]   out_in;
   logic [26:0]               mag_ff;
   logic [26:0]               mag_in;
   logic [26:0]               omag_ff;

   logic signed [40:0]        gprod [2];
   logic signed [28:0]        diff;
   logic [15:0]               coef_sel;
   logic signed [28:0]        env_ext;
   logic signed [28:0]        den;
   logic [26:0]               lim;
   logic [27:0]               nmag [2];
   logic [29:0]               trial [2];

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         gprod[i]  = $signed(smp_ff[i]) * $signed({1'b0, cfg.preamp_gain});
         scl_in[i] = gprod[i][39:12];
      end

      peak_in  = ($signed(scl_ff[0]) > $signed(scl_ff[1])) ? scl_ff[0] : scl_ff[1];
      diff     = {env_ff[27], env_ff} - {peak_in[27], peak_in};
      coef_sel = (peak_in > env_ff) ? cfg.attack_coef : cfg.release_coef;
      eprod_in = diff * $signed({1'b0, coef_sel});

      env_in = peak_ff + eprod_ff[43:16];

      env_abs_in = env_ff[27] ? 28'(-env_ff) : env_ff;
      lim        = {cfg.limit_level, 11'b0};
      bypass_in  = env_abs_in <= {1'b0, lim};
      env_ext    = {env_ff[27], env_ff};
      if (env_abs_in > ONE_Q23) begin
         den = env_ext;
      end else begin
         den = $signed({1'b0, ONE_Q23}) + env_ext - $signed({2'b0, lim});
      end
      dmag_in = den[28] ? 29'(-den) : den;
      mag_in  = env_abs_in[27] ? '1 : env_abs_in[26:0];

      for (int i = 0; i < 2; i++) begin
         nmag[i]   = scl_ff[i][27] ? 28'(-scl_ff[i]) : scl_ff[i];
         ovf_in[i] = {2'b0, nmag[i]} >= {dmag_in, 1'b0};
         neg_in[i] = scl_ff[i][27] ^ den[28];
         nb_in[i]  = nmag[i][0];
      end

      for (int i = 0; i < 2; i++) begin
         trial[i] = {rem_ff[i], nb_ff[i]};
         if (trial[i] >= {1'b0, dmag_ff}) begin
            rem_in[i] = 29'(trial[i] - {1'b0, dmag_ff});
            q_in[i]   = {q_ff[i][22:0], 1'b1};
         end else begin
            rem_in[i] = trial[i][28:0];
            q_in[i]   = {q_ff[i][22:0], 1'b0};
         end
         out_in[i] = bypass_ff ? smp_ff[i] : div_result(ovf_ff[i], neg_ff[i], q_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         env_ff <= '0;
      end else if (cmd.env_update) begin
         env_ff <= env_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         smp_ff[0] <= sample_left;
         smp_ff[1] <= sample_right;
      end
      if (cmd.scale) begin
         scl_ff <= scl_in;
      end
      if (cmd.env_mult) begin
         peak_ff  <= peak_in;
         eprod_ff <= eprod_in;
      end
      if (cmd.prep) begin
         env_abs_ff <= env_abs_in;
         bypass_ff  <= bypass_in;
         dmag_ff    <= dmag_in;
         ovf_ff     <= ovf_in;
         neg_ff     <= neg_in;
         nb_ff      <= nb_in;
         mag_ff     <= mag_in;
         for (int i = 0; i < 2; i++) begin
            rem_ff[i] <= {2'b0, nmag[i][27:1]};
            q_ff[i]   <= '0;
         end
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
         nb_ff  <= '0;
      end
      if (cmd.out_load) begin
         out_ff  <= out_in;
         omag_ff <= mag_ff;
      end
   end

   assign status.bypass = bypass_in;
   assign out_left      = out_ff[0];
   assign out_right     = out_ff[1];
   assign env_magnitude = omag_ff;

   a_rem_left: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step && !ovf_ff[0] |-> rem_ff[0] < dmag_ff)
      else $error("left remainder not below divisor");

   a_rem_right: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step && !ovf_ff[1] |-> rem_ff[1] < dmag_ff)
      else $error("right remainder not below divisor");

   a_env_abs: assert property (@(posedge clock) disable iff (reset)
      cmd.prep |=> env_abs_ff <= 28'h8000000)
      else $error("envelope magnitude out of range");

endmodule
